[rtl/pwm_period_duty_meter_defines.svh]
// Assertion macros shared by the checker of the PWM period and duty meter.
`ifndef PWM_PERIOD_DUTY_METER_DEFINES_SVH
`define PWM_PERIOD_DUTY_METER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pdm_pkg.sv]
// Package of the PWM period and duty meter: beat types, codes and constants.
`default_nettype none

package pdm_pkg;

  localparam int unsigned STAMP_W              = 16;
  localparam int unsigned TICKS_W              = 17;
  localparam int unsigned RATE_W               = 20;
  localparam int unsigned DUTY_W               = 7;
  localparam int unsigned COUNTER_BITS_DEFAULT = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd8000;
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;

  typedef enum logic [1:0] {
    FUNC_RISE = 2'd0,
    FUNC_FALL = 2'd1,
    FUNC_OVF  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    PH_WAIT_FIRST = 2'd0,
    PH_WAIT_FALL  = 2'd1,
    PH_WAIT_RISE  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_HOLD   = 2'd2
  } meter_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [STAMP_W-1:0] capture_stamp;
  } in_t;

  typedef struct packed {
    logic [TICKS_W-1:0] period_ticks;
    logic [TICKS_W-1:0] high_ticks;
    logic [RATE_W-1:0]  frequency;
    logic [DUTY_W-1:0]  duty_percent;
    logic               divide_error;
  } out_t;

endpackage

`default_nettype wire

[rtl/pdm_serial_div.sv]
// Bit-serial restoring divider: one quotient bit per clock cycle.
`default_nettype none

module pdm_serial_div #(
  parameter int unsigned DIVIDEND_W = 20,
  parameter int unsigned DIVISOR_W  = 17
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
    rem_d   = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_d   = {quo_q[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/pdm_tracker.sv]
// Edge tracker: follows the signal phase and measures intervals between stamps.
`default_nettype none

module pdm_tracker #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire pdm_pkg::in_t     item_i,
  output logic                  close_o,
  output logic [COUNTER_BITS:0] period_o,
  output logic [COUNTER_BITS:0] high_o
);

  import pdm_pkg::*;

  localparam int unsigned IW = COUNTER_BITS + 1;

  phase_e                  phase_q, phase_d;
  logic [COUNTER_BITS-1:0] start_q, start_d;
  logic [IW-1:0]           high_q, high_d;
  logic                    ovf_q, ovf_d;
  logic [COUNTER_BITS-1:0] stamp;
  logic [IW-1:0]           interval;
  logic                    close;

  // A seen overflow adds one full counter span to the stamp.
  assign stamp    = COUNTER_BITS'(item_i.capture_stamp);
  assign interval = {ovf_q, stamp} - {1'b0, start_q};

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    high_d  = high_q;
    ovf_d   = ovf_q;
    close   = 1'b0;
    if (accept_i) begin
      if (item_i.func == FUNC_OVF) begin
        ovf_d = 1'b1;
      end else if (item_i.func == FUNC_RISE || item_i.func == FUNC_FALL) begin
        case (phase_q)
          PH_WAIT_FALL: begin
            if (item_i.func == FUNC_FALL) begin
              high_d  = interval;
              phase_d = PH_WAIT_RISE;
            end
          end
          PH_WAIT_RISE: begin
            if (item_i.func == FUNC_RISE) begin
              close   = 1'b1;
              start_d = stamp;
              ovf_d   = 1'b0;
              phase_d = PH_WAIT_FALL;
            end
          end
          default: begin
            if (item_i.func == FUNC_RISE) begin
              start_d = stamp;
              ovf_d   = 1'b0;
              phase_d = PH_WAIT_FALL;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_FIRST;
      start_q <= '0;
      high_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      start_q <= start_d;
      high_q  <= high_d;
      ovf_q   <= ovf_d;
    end
  end

  assign close_o  = close;
  assign period_o = interval;
  assign high_o   = high_q;

endmodule

`default_nettype wire

[rtl/pwm_period_duty_meter.sv]
// Top level of the PWM period and duty meter.
//
// Usage: timer events arrive as beats on the input channel (in_valid_i,
// in_ready_o, in_data_i). A rising capture, a falling capture or a counter
// overflow is taken as one beat. The rising edge that closes a period
// starts two bit-serial dividers, one for the frequency (rate_scale over the
// period) and one for the duty percent (high time times 100 over the
// period). Both produce one quotient bit per cycle; the duty divider has
// COUNTER_BITS + 8 bits to work through, the frequency divider 20, and at
// the default of 16 the duty divider sets the pace. While the dividers run,
// in_ready_o is low; every other event leaves it high. When both are done,
// the result beat is loaded into an output register on the output channel
// (out_valid_o, out_ready_i, out_data_o), where results wait, so the meter
// keeps taking events while the receiver stalls. A closing edge that
// arrives while a result beat still waits is taken and its division runs,
// but in_ready_o then stays low until the waiting beat has been taken. The
// rate_scale register is written through cfg_valid_i / cfg_data_i and is
// always ready. Reset returns the meter to waiting for its first rising
// edge, empties the output register and sets rate_scale to 8000.
`default_nettype none

module pwm_period_duty_meter #(
  parameter int unsigned COUNTER_BITS = pdm_pkg::COUNTER_BITS_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire pdm_pkg::in_t               in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output pdm_pkg::out_t                   out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [pdm_pkg::RATE_W-1:0] cfg_data_i
);

  import pdm_pkg::*;

  // Intervals carry one bit above the counter for a seen overflow.
  localparam int unsigned IW     = COUNTER_BITS + 1;
  // High time times 100 needs seven more bits.
  localparam int unsigned PROD_W = IW + DUTY_W;

  meter_state_e      state_q, state_d;
  logic [RATE_W-1:0] rate_scale_q;
  logic [IW-1:0]     period_q;
  logic [IW-1:0]     high_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q;
  out_t              result;
  logic              accept;
  logic              close;
  logic [IW-1:0]     period;
  logic [IW-1:0]     high;
  logic              freq_busy;
  logic              duty_busy;
  logic [RATE_W-1:0] freq_quo;
  logic [PROD_W-1:0] duty_quo;
  logic [PROD_W-1:0] high_scaled;
  logic              slot_free;
  logic              load;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_scale_q <= RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_scale_q <= cfg_data_i;
    end
  end

  pdm_tracker #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_data_i),
    .close_o (close),
    .period_o(period),
    .high_o  (high)
  );

  assign high_scaled = PROD_W'(high) * PROD_W'(DUTY_FULL);

  pdm_serial_div #(
    .DIVIDEND_W(RATE_W),
    .DIVISOR_W (IW)
  ) u_freq_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (close),
    .dividend_i(rate_scale_q),
    .divisor_i (period),
    .busy_o    (freq_busy),
    .quotient_o(freq_quo)
  );

  pdm_serial_div #(
    .DIVIDEND_W(PROD_W),
    .DIVISOR_W (IW)
  ) u_duty_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (close),
    .dividend_i(high_scaled),
    .divisor_i (period),
    .busy_o    (duty_busy),
    .quotient_o(duty_quo)
  );

  // The period and high time of the closed period are kept for the result.
  always_ff @(posedge clk_i) begin
    if (close) begin
      period_q <= period;
      high_q   <= high;
    end
  end

  // A zero period gives an error flag; the quotients are then forced to zero.
  always_comb begin
    result.period_ticks = TICKS_W'(period_q);
    result.high_ticks   = TICKS_W'(high_q);
    result.divide_error = (period_q == '0);
    if (result.divide_error) begin
      result.frequency    = '0;
      result.duty_percent = '0;
    end else begin
      result.frequency    = freq_quo;
      result.duty_percent = (duty_quo > PROD_W'(DUTY_FULL)) ? DUTY_FULL
                                                            : duty_quo[DUTY_W-1:0];
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    load       = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (close) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!freq_busy && !duty_busy) begin
          if (slot_free) begin
            load    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register: filled from the dividers, emptied by the receiver.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[rtl/pdm_checker.sv]
// Port checker of the PWM period and duty meter, bound to the top level.
`default_nettype none
`include "pwm_period_duty_meter_defines.svh"

module pdm_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire pdm_pkg::out_t out_data_o
);

  import pdm_pkg::*;

  `PDM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat changed while stalled")
  `PDM_ASSERT_NOW(a_duty_range, clk_i, rst_ni, out_valid_o, out_data_o.duty_percent <= DUTY_FULL, "duty percent above full")
  `PDM_ASSERT_NOW(a_error_zeroes, clk_i, rst_ni, out_valid_o && out_data_o.divide_error, out_data_o.period_ticks == '0 && out_data_o.frequency == '0 && out_data_o.duty_percent == '0, "error beat carries non-zero fields")
  `PDM_ASSERT_NOW(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o), "result beat appeared without a division")

endmodule

bind pwm_period_duty_meter pdm_checker u_pdm_checker (.*);

`default_nettype wire

[tb/sv/tb_pwm_period_duty_meter.sv]
// Self-checking testbench for the PWM period and duty meter.
`timescale 1ns / 1ps

module tb_pwm_period_duty_meter;

  import pdm_pkg::*;

  // The package names only the three live event kinds; code 3 is spare and
  // must be swallowed by the meter without touching its state.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Settling time that lets any work still in flight finish.
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned EDGES_PER_PHASE  = 500;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;

  // One line of the directed script: the event beat, and where the answer is
  // obvious, the reading typed in by hand.
  typedef struct packed {
    in_t  ev;
    logic typed;
    out_t reading;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [RATE_W-1:0]   cfg_data_i;

  // Mirror of the meter's state, kept up to date as beats are accepted.
  phase_e              meter_phase;
  logic [STAMP_W-1:0]  period_start;
  logic [TICKS_W-1:0]  high_span;
  logic                overflow_flag;
  logic [RATE_W-1:0]   rate_scale_now;

  // Readings owed by the meter, oldest first.
  out_t                pending_readings[$];
  script_row_t         script[$];

  int unsigned         fail_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         in_idle_pct;
  int unsigned         out_idle_pct;

  // State of the synthetic PWM waveform used for the random part.
  logic [STAMP_W-1:0]  wave_stamp;
  logic [1:0]          wave_edge;
  in_t                 held_edge;
  logic                edge_held;
  int unsigned         wave_edge_count;

  pwm_period_duty_meter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost reading ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver decides on each falling edge whether it will take a beat
  // at the next rising edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  // Works out what the meter must do with one accepted event beat. It
  // returns 1 and fills in the reading when the beat closes a period.
  function automatic logic measure_event(input in_t ev, output out_t reading);
    logic [TICKS_W-1:0] span;
    logic [31:0]        high_w;
    logic [31:0]        span_w;
    logic [31:0]        duty_w;
    reading = '0;
    measure_event = 1'b0;
    // Interval from the period start, widened by one counter turn if an
    // overflow has been seen; it wraps at 17 bits like the hardware.
    span = {1'b0, ev.capture_stamp} + (overflow_flag ? 17'h10000 : 17'h0)
           - {1'b0, period_start};
    if (ev.func == FUNC_OVF) begin
      overflow_flag = 1'b1;
    end else if (ev.func == FUNC_UNUSED) begin
      // Spare code: nothing changes.
    end else if (meter_phase == PH_WAIT_FALL) begin
      if (ev.func == FUNC_FALL) begin
        high_span   = span;
        meter_phase = PH_WAIT_RISE;
      end
    end else if (meter_phase == PH_WAIT_RISE) begin
      if (ev.func == FUNC_RISE) begin
        reading.period_ticks = span;
        reading.high_ticks   = high_span;
        if (span == '0) begin
          reading.divide_error = 1'b1;
        end else begin
          high_w = 32'(high_span);
          span_w = 32'(span);
          duty_w = (high_w * 32'd100) / span_w;
          reading.frequency    = rate_scale_now / RATE_W'(span);
          reading.duty_percent = (duty_w > 32'd100) ? DUTY_FULL : duty_w[DUTY_W-1:0];
        end
        period_start  = ev.capture_stamp;
        overflow_flag = 1'b0;
        meter_phase   = PH_WAIT_FALL;
        measure_event = 1'b1;
      end
    end else if (ev.func == FUNC_RISE) begin
      // First rising edge after reset opens the first period.
      period_start  = ev.capture_stamp;
      overflow_flag = 1'b0;
      meter_phase   = PH_WAIT_FALL;
    end
  endfunction

  task automatic check_field(input string name, input logic [RATE_W-1:0] want,
                             input logic [RATE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Every result beat taken from the meter is held against the oldest
  // reading still owed.
  always @(posedge clk_i) begin : check_readings
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        $error("result beat arrived with no reading owed");
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("period_ticks", RATE_W'(want.period_ticks),
                    RATE_W'(out_data_o.period_ticks));
        check_field("high_ticks",   RATE_W'(want.high_ticks),
                    RATE_W'(out_data_o.high_ticks));
        check_field("frequency",    want.frequency, out_data_o.frequency);
        check_field("duty_percent", RATE_W'(want.duty_percent),
                    RATE_W'(out_data_o.duty_percent));
        check_field("divide_error", RATE_W'(want.divide_error),
                    RATE_W'(out_data_o.divide_error));
      end
    end
  end

  // Presents one event beat, with random idle cycles in front of it, and
  // holds it until the meter takes it. A hand-typed reading, where given,
  // stands in for the predicted one.
  task automatic drive_event(input in_t ev, input logic typed, input out_t typed_reading);
    out_t reading;
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (measure_event(ev, reading)) begin
      pending_readings.push_back(typed ? typed_reading : reading);
    end else if (typed) begin
      $error("script row carries a reading but its beat closes no period");
      fail_count++;
    end
  endtask

  // Lets the meter run dry: the sender stops, every owed reading must come
  // back, and then the dividers are given time to finish anything left.
  task automatic wait_until_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_rate_scale(input logic [RATE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    rate_scale_now = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] func, input logic [STAMP_W-1:0] stamp,
                         input logic typed, input logic [TICKS_W-1:0] period,
                         input logic [TICKS_W-1:0] high, input logic [RATE_W-1:0] freq,
                         input logic [DUTY_W-1:0] duty, input logic err);
    script_row_t row;
    row.ev.func                = func;
    row.ev.capture_stamp       = stamp;
    row.typed                  = typed;
    row.reading.period_ticks   = period;
    row.reading.high_ticks     = high;
    row.reading.frequency      = freq;
    row.reading.duty_percent   = duty;
    row.reading.divide_error   = err;
    script.push_back(row);
  endtask

  // Builds the next beat of a mostly well-formed PWM waveform: rising and
  // falling edges alternate on a free-running 16-bit counter, and an overflow
  // beat goes out ahead of any edge whose stamp has wrapped. About one beat
  // in eight is noise with a random code and stamp.
  task automatic make_event(output in_t ev);
    int unsigned  delta;
    logic [16:0]  sum;
    if (edge_held) begin
      ev        = held_edge;
      edge_held = 1'b0;
    end else if ($urandom_range(99) < 12) begin
      ev.func          = 2'($urandom_range(3));
      ev.capture_stamp = STAMP_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       delta = $urandom_range(3);
        1:       delta = $urandom_range(255);
        2:       delta = $urandom_range(8191);
        default: delta = $urandom_range(65535);
      endcase
      sum        = {1'b0, wave_stamp} + delta[16:0];
      wave_stamp = sum[STAMP_W-1:0];
      held_edge.func          = wave_edge;
      held_edge.capture_stamp = wave_stamp;
      wave_edge  = (wave_edge == FUNC_RISE) ? FUNC_FALL : FUNC_RISE;
      wave_edge_count++;
      if (sum[16]) begin
        ev.func          = FUNC_OVF;
        ev.capture_stamp = STAMP_W'($urandom);
        edge_held        = 1'b1;
      end else begin
        ev = held_edge;
      end
    end
  endtask

  task automatic run_random_phase();
    in_t ev;
    wave_edge_count = 0;
    while (wave_edge_count < EDGES_PER_PHASE) begin
      make_event(ev);
      drive_event(ev, 1'b0, '0);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_idle_pct   = 20;
    out_idle_pct  = 86;

    meter_phase    = PH_WAIT_FIRST;
    period_start   = '0;
    high_span      = '0;
    overflow_flag  = 1'b0;
    rate_scale_now = RATE_RESET;

    wave_stamp      = STAMP_W'($urandom);
    wave_edge       = FUNC_RISE;
    edge_held       = 1'b0;
    wave_edge_count = 0;

    // Directed script, run at the reset value of rate_scale (8000).
    // A falling edge and the spare code are both ignored before the first
    // rising edge; a rising edge is ignored while a falling one is awaited.
    add_row(FUNC_FALL,   16'd100,   1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_UNUSED, 16'hFFFF,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'd0,     1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'd50,    1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_FALL,   16'd250,   1'b0, '0, '0, '0, '0, 1'b0);
    // A plain quarter-duty period of 1000 ticks.
    add_row(FUNC_RISE,   16'd1000,  1'b1, 17'd1000, 17'd250, 20'd8, 7'd25, 1'b0);
    // Zero period: the error flag is raised and both quotients are zero.
    add_row(FUNC_FALL,   16'd1000,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'd1000,  1'b1, 17'd0, 17'd0, 20'd0, 7'd0, 1'b1);
    // Two overflows count as one turn of the counter.
    add_row(FUNC_OVF,    16'hA5A5,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_OVF,    16'h5A5A,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_FALL,   16'd1000,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'd1000,  1'b1, 17'd65536, 17'd65536, 20'd0, 7'd100, 1'b0);
    // Stamp running backwards with no overflow wraps at 17 bits.
    add_row(FUNC_FALL,   16'hFFFF,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'd500,   1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_FALL,   16'd600,   1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_OVF,    16'h0000,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'd499,   1'b0, '0, '0, '0, '0, 1'b0);
    // High time far beyond a one-tick period: duty saturates at full.
    add_row(FUNC_FALL,   16'd0,     1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'd500,   1'b1, 17'd1, 17'd130573, 20'd8000, 7'd100, 1'b0);
    // Long intervals across an overflow, fall and rise stamps both at full scale.
    add_row(FUNC_OVF,    16'hFFFF,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_FALL,   16'hFFFF,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_OVF,    16'h1234,  1'b0, '0, '0, '0, '0, 1'b0);
    add_row(FUNC_RISE,   16'hFFFF,  1'b1, 17'd130571, 17'd130571, 20'd0, 7'd100, 1'b0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      drive_event(script[i].ev, script[i].typed, script[i].reading);
    end

    // Sender light, receiver mostly stalled, smallest non-zero rate_scale.
    wait_until_idle();
    write_rate_scale(20'd1);
    run_random_phase();

    // Sender mostly idle, receiver light, largest rate_scale.
    wait_until_idle();
    in_idle_pct  = 86;
    out_idle_pct = 20;
    write_rate_scale(20'hFFFFF);
    run_random_phase();

    // Both sides flat out with an arbitrary rate_scale.
    wait_until_idle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_rate_scale(RATE_W'($urandom_range(1, 20'hFFFFF)));
    run_random_phase();

    wait_until_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
